/* rtl/core/bpms_pkg.sv */
// ----------------------------------------------------------------------------
// Block power meter with squelch: shared package
// Types, constants and state encodings used across the meter's front end,
// level engine and queues.
// ----------------------------------------------------------------------------
`default_nettype none

package bpms_pkg;

   // Accumulator width and saturation value
   localparam int SUM_W = 45;
   localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

   // 16*10*log10(2) in Q16
   localparam logic [21:0] LOG_COEF = 22'd3156528;
   // 16*10*log10(2^30), removes the Q1.30 scale of the squares
   localparam logic signed [14:0] FRAC_OFFSET = 15'sd1445;

   // Level limits and reset values, 1/16 dB
   localparam logic signed [12:0] LEVEL_MIN  = -13'sd4096;
   localparam logic signed [12:0] LEVEL_MAX  = 13'sd4095;
   localparam logic signed [12:0] LEVEL_CAP  = -13'sd208;
   localparam logic signed [12:0] INST_RESET = 13'sd432;
   localparam logic signed [12:0] AVG_RESET  = -13'sd2032;

   // Register reset values
   localparam logic signed [11:0] SQUELCH_RESET = -12'sd1600;
   localparam logic signed [10:0] CORR_RESET    = -11'sd640;

   // Average: floor((9*avg + inst + 40960 + 5) / 10) - 4096
   localparam logic signed [17:0] AVG_BIAS = 18'sd40965;
   localparam logic [15:0] RECIP10 = 16'd52429;  // ceil(2^19 / 10)
   localparam int RECIP_SHIFT = 19;

   // Register map
   typedef enum logic {
      REG_SQUELCH_LEVEL    = 1'b0,
      REG_LEVEL_CORRECTION = 1'b1
   } reg_index_type;

   // Entry of the queue between front end and level engine
   typedef struct packed {
      logic signed [15:0] re;
      logic signed [15:0] im;
      logic               last;
      logic [SUM_W-1:0]   sum;   // block sum including this sample
   } item_type;

   // Result entry
   typedef struct packed {
      logic signed [15:0] gated_re;
      logic signed [15:0] gated_im;
      logic               muted;
      logic               block_done;
      logic signed [12:0] inst_level;
      logic signed [12:0] avg_level;
   } result_type;

   // Level engine handshake
   typedef struct packed {
      logic             start;
      logic [SUM_W-1:0] sum;
   } log_req_type;

   typedef struct packed {
      logic               done;
      logic signed [12:0] level;
   } log_rsp_type;

   typedef enum logic [1:0] {
      BACK_RUN,
      BACK_WAIT,
      BACK_AVG
   } back_state_type;

   typedef enum logic [2:0] {
      LOG_IDLE,
      LOG_NORM,
      LOG_SQR,
      LOG_MUL,
      LOG_FIN
   } log_state_type;

endpackage

`default_nettype wire

/* rtl/core/bpms_fifo.sv */
// ----------------------------------------------------------------------------
// Register queue
// Small first-in first-out queue in flip-flops, one write and one read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bpms_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   // Advance pointers with wrap at the queue depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed entries
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");

endmodule

`default_nettype wire

/* rtl/core/bpms_front.sv */
// ----------------------------------------------------------------------------
// Power meter front end
// Takes samples, squares them and keeps the saturating block power sum.
// ----------------------------------------------------------------------------
`default_nettype none

module bpms_front
   import bpms_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   output logic                    full,
   input  wire logic signed [15:0] sample_re,
   input  wire logic signed [15:0] sample_im,
   input  wire logic               is_last,
   output logic                    q_push,
   output item_type                q_item,
   input  wire logic               q_full
);

   logic               stage_valid_ff, stage_valid_in;
   logic signed [15:0] re_ff, im_ff;
   logic               last_ff;
   logic [30:0]        sq_re_ff, sq_im_ff;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic signed [31:0] re_sq, im_sq;
   logic [31:0]        power;
   logic [SUM_W:0]     sum_wide;
   logic [SUM_W-1:0]   sum_sat;
   logic               accept;

   // Hold the staged request while the queue is full
   assign q_push = stage_valid_ff && !q_full;
   assign full   = stage_valid_ff && q_full;
   assign accept = push && !full;

   // Square both parts ahead of the accumulator
   assign re_sq = sample_re * sample_re;
   assign im_sq = sample_im * sample_im;

   // Add the sample power, saturate at the top of the sum
   assign power    = {1'b0, sq_re_ff} + {1'b0, sq_im_ff};
   assign sum_wide = {1'b0, sum_ff} + (SUM_W + 1)'(power);
   assign sum_sat  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];

   assign q_item.re   = re_ff;
   assign q_item.im   = im_ff;
   assign q_item.last = last_ff;
   assign q_item.sum  = sum_sat;

   assign stage_valid_in = accept || (stage_valid_ff && !q_push);

   // Restart the sum after the last sample of a block
   always_comb begin
      sum_in = sum_ff;
      if (q_push) begin
         sum_in = last_ff ? '0 : sum_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         sum_ff         <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         sum_ff         <= sum_in;
      end
   end

   // Load the stage on an accepted request
   always_ff @(posedge clock) begin
      if (accept) begin
         re_ff    <= sample_re;
         im_ff    <= sample_im;
         last_ff  <= is_last;
         sq_re_ff <= re_sq[30:0];
         sq_im_ff <= im_sq[30:0];
      end
   end

   a_sum_cleared: assert property (@(posedge clock) disable iff (reset)
      (q_push && last_ff) |=> (sum_ff == '0))
      else $error("block sum not cleared after last sample");

endmodule

`default_nettype wire

/* rtl/core/bpms_log.sv */
// ----------------------------------------------------------------------------
// Level engine
// Turns a block power sum into a level in 1/16 dB: normalize, sixteen
// squaring steps for the log2 fraction, scale by 10*log10(2), correct.
// ----------------------------------------------------------------------------
`default_nettype none

module bpms_log
   import bpms_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire log_req_type        req,
   input  wire logic signed [10:0] corr,
   output log_rsp_type             rsp
);

   log_state_type      state_ff, state_in;
   logic [SUM_W-1:0]   x_ff, x_in;
   logic [5:0]         e_ff, e_in;
   logic [30:0]        m_ff, m_in;
   logic [15:0]        frac_ff, frac_in;
   logic [3:0]         step_ff, step_in;
   logic [43:0]        prod_ff, prod_in;
   logic signed [12:0] level_ff, level_in;
   logic               done_ff, done_in;
   logic [61:0]        m_sq;
   logic [31:0]        m_next;
   logic [44:0]        rounded;
   logic [12:0]        scaled;
   logic signed [14:0] level_raw;

   // Square the mantissa, keep Q1.30
   assign m_sq   = 62'(m_ff) * 62'(m_ff);
   assign m_next = m_sq[61:30];

   // Round the scaled log and apply the offsets
   assign rounded   = 45'(prod_ff) + (45'(1) << 31);
   assign scaled    = rounded[44:32];
   assign level_raw = $signed({2'b00, scaled}) - FRAC_OFFSET + 15'(corr);

   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      e_in     = e_ff;
      m_in     = m_ff;
      frac_in  = frac_ff;
      step_in  = step_ff;
      prod_in  = prod_ff;
      level_in = level_ff;
      done_in  = 1'b0;
      case (state_ff)
         LOG_IDLE: begin
            if (req.start) begin
               if (req.sum == '0) begin
                  level_in = LEVEL_MIN;
                  done_in  = 1'b1;
               end else begin
                  x_in     = req.sum;
                  e_in     = 6'(SUM_W - 1);
                  state_in = LOG_NORM;
               end
            end
         end
         LOG_NORM: begin
            // Shift the top set bit up to the word's top bit
            if (x_ff[SUM_W-1 -: 8] == '0) begin
               x_in = x_ff << 8;
               e_in = e_ff - 6'd8;
            end else if (!x_ff[SUM_W-1]) begin
               x_in = x_ff << 1;
               e_in = e_ff - 6'd1;
            end else begin
               m_in     = x_ff[SUM_W-1 -: 31];
               frac_in  = '0;
               step_in  = '0;
               state_in = LOG_SQR;
            end
         end
         LOG_SQR: begin
            // One fraction bit per square
            if (m_next[31]) begin
               m_in    = m_next[31:1];
               frac_in = {frac_ff[14:0], 1'b1};
            end else begin
               m_in    = m_next[30:0];
               frac_in = {frac_ff[14:0], 1'b0};
            end
            step_in = step_ff + 1'b1;
            if (step_ff == 4'd15) begin
               state_in = LOG_MUL;
            end
         end
         LOG_MUL: begin
            prod_in  = 44'({e_ff, frac_ff}) * 44'(LOG_COEF);
            state_in = LOG_FIN;
         end
         LOG_FIN: begin
            if (level_raw < 15'(LEVEL_MIN)) begin
               level_in = LEVEL_MIN;
            end else if (level_raw > 15'(LEVEL_MAX)) begin
               level_in = LEVEL_MAX;
            end else begin
               level_in = level_raw[12:0];
            end
            done_in  = 1'b1;
            state_in = LOG_IDLE;
         end
         default: begin
            state_in = LOG_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LOG_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      e_ff     <= e_in;
      m_ff     <= m_in;
      frac_ff  <= frac_in;
      step_ff  <= step_in;
      prod_ff  <= prod_in;
      level_ff <= level_in;
   end

   assign rsp.done  = done_ff;
   assign rsp.level = level_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      req.start |-> (state_ff == LOG_IDLE))
      else $error("level engine started while busy");

endmodule

`default_nettype wire

/* rtl/core/bpms_back.sv */
// ----------------------------------------------------------------------------
// Power meter back end
// Gates samples by the held average, runs the level engine at block ends
// and keeps the instant and averaged levels.
// ----------------------------------------------------------------------------
`default_nettype none

module bpms_back
   import bpms_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic signed [11:0] squelch_level,
   input  wire logic signed [10:0] level_correction,
   input  wire logic               q_empty,
   input  wire item_type           q_item,
   output logic                    q_pop,
   input  wire logic               out_full,
   output logic                    out_push,
   output result_type              out_data
);

   back_state_type     state_ff, state_in;
   logic signed [12:0] inst_ff, inst_in;
   logic signed [12:0] avg_ff, avg_in;
   logic signed [15:0] hold_re_ff, hold_im_ff;
   logic               hold_mute_ff;
   logic               hold_load;
   logic               mute;
   log_req_type        log_req;
   log_rsp_type        log_rsp;
   logic signed [17:0] avg_x;
   logic signed [17:0] avg_sum;
   logic [32:0]        div_prod;
   logic [13:0]        div_q;
   logic signed [12:0] avg_new;

   function automatic logic signed [12:0] cap_level(input logic signed [12:0] v);
      return (v > LEVEL_CAP) ? LEVEL_CAP : v;
   endfunction

   bpms_log u_log (
      .clock (clock),
      .reset (reset),
      .req   (log_req),
      .corr  (level_correction),
      .rsp   (log_rsp)
   );

   // Mute from the average left by earlier blocks
   assign mute = avg_ff < 13'(squelch_level);

   // Average update, division by ten through the reciprocal
   assign avg_x    = 18'(avg_ff);
   assign avg_sum  = (avg_x <<< 3) + avg_x + 18'(inst_ff) + AVG_BIAS;
   assign div_prod = 33'(avg_sum[16:0]) * 33'(RECIP10);
   assign div_q    = div_prod[32:RECIP_SHIFT];
   assign avg_new  = 13'($signed({1'b0, div_q[12:0]}) - 14'sd4096);

   always_comb begin
      state_in    = state_ff;
      inst_in     = inst_ff;
      avg_in      = avg_ff;
      hold_load   = 1'b0;
      q_pop       = 1'b0;
      out_push    = 1'b0;
      log_req     = '0;
      log_req.sum = q_item.sum;
      out_data.gated_re   = mute ? 16'sd0 : q_item.re;
      out_data.gated_im   = mute ? 16'sd0 : q_item.im;
      out_data.muted      = mute;
      out_data.block_done = 1'b0;
      out_data.inst_level = cap_level(inst_ff);
      out_data.avg_level  = cap_level(avg_ff);
      case (state_ff)
         BACK_RUN: begin
            if (!q_empty && !out_full) begin
               q_pop = 1'b1;
               if (q_item.last) begin
                  // Park the sample and start the level engine
                  log_req.start = 1'b1;
                  hold_load     = 1'b1;
                  state_in      = BACK_WAIT;
               end else begin
                  out_push = 1'b1;
               end
            end
         end
         BACK_WAIT: begin
            if (log_rsp.done) begin
               inst_in  = log_rsp.level;
               state_in = BACK_AVG;
            end
         end
         BACK_AVG: begin
            // Result slot stays free since only this side pushes
            avg_in              = avg_new;
            out_push            = 1'b1;
            out_data.gated_re   = hold_mute_ff ? 16'sd0 : hold_re_ff;
            out_data.gated_im   = hold_mute_ff ? 16'sd0 : hold_im_ff;
            out_data.muted      = hold_mute_ff;
            out_data.block_done = 1'b1;
            out_data.avg_level  = cap_level(avg_new);
            state_in            = BACK_RUN;
         end
         default: begin
            state_in = BACK_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BACK_RUN;
         inst_ff  <= INST_RESET;
         avg_ff   <= AVG_RESET;
      end else begin
         state_ff <= state_in;
         inst_ff  <= inst_in;
         avg_ff   <= avg_in;
      end
   end

   // Hold the last sample of a block while its level is worked out
   always_ff @(posedge clock) begin
      if (hold_load) begin
         hold_re_ff   <= q_item.re;
         hold_im_ff   <= q_item.im;
         hold_mute_ff <= mute;
      end
   end

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      out_push |-> !out_full)
      else $error("result pushed into a full queue");

endmodule

`default_nettype wire

/* rtl/core/block_power_meter_squelch_unit.sv */
// ----------------------------------------------------------------------------
// Block power meter with squelch
// Passes complex samples through or mutes them, measures block power in dB
// and keeps an exponential average of the block levels.
// ----------------------------------------------------------------------------
//  channel   | handshake             | payload
//  ----------+-----------------------+-----------------------------------------
//  request   | push / full           | req_sample_re, req_sample_im, req_is_last
//  response  | pop / empty           | rsp_gated_re, rsp_gated_im, rsp_muted,
//            |                       | rsp_block_done, rsp_inst_level,
//            |                       | rsp_avg_level
//  registers | psel/penable/pwrite   | paddr, pwdata, prdata, pready
//
//  Inside a block one request per cycle while full stays low; a request
//  passes the front stage register and the middle queue before it reaches
//  the result queue. The last sample of a block holds the back end while
//  the level engine normalizes the sum and runs its sixteen squarings (an
//  all-zero sum skips both); the front end keeps taking requests until the
//  middle queue fills.
//  Synchronous active-high reset clears queues and sum and presets levels;
//  full rises when the front stage is occupied and the middle queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module block_power_meter_squelch_unit
   import bpms_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // Requests
   input  wire logic               push,
   output logic                    full,
   input  wire logic signed [15:0] req_sample_re,
   input  wire logic signed [15:0] req_sample_im,
   input  wire logic               req_is_last,
   // Responses
   output logic                    empty,
   input  wire logic               pop,
   output logic signed [15:0]      rsp_gated_re,
   output logic signed [15:0]      rsp_gated_im,
   output logic                    rsp_muted,
   output logic                    rsp_block_done,
   output logic signed [12:0]      rsp_inst_level,
   output logic signed [12:0]      rsp_avg_level,
   // Registers
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [2:0]         paddr,
   input  wire logic [31:0]        pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);

   localparam int RSP_DEPTH = 2;

   logic signed [11:0] squelch_ff, squelch_in;
   logic signed [10:0] corr_ff, corr_in;
   logic               reg_write;
   reg_index_type      reg_index;

   logic       mid_push, mid_full, mid_pop, mid_empty;
   item_type   mid_in_item, mid_out_item;
   logic       res_push, res_full;
   result_type res_in, res_out;

   // Register port
   assign pready    = 1'b1;
   assign reg_write = psel && penable && pwrite;
   assign reg_index = reg_index_type'(paddr[2]);

   always_comb begin
      squelch_in = squelch_ff;
      corr_in    = corr_ff;
      prdata     = '0;
      case (reg_index)
         REG_SQUELCH_LEVEL: begin
            prdata = 32'(squelch_ff);
            if (reg_write) begin
               squelch_in = pwdata[11:0];
            end
         end
         REG_LEVEL_CORRECTION: begin
            prdata = 32'(corr_ff);
            if (reg_write) begin
               corr_in = pwdata[10:0];
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         squelch_ff <= SQUELCH_RESET;
         corr_ff    <= CORR_RESET;
      end else begin
         squelch_ff <= squelch_in;
         corr_ff    <= corr_in;
      end
   end

   bpms_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .sample_re (req_sample_re),
      .sample_im (req_sample_im),
      .is_last   (req_is_last),
      .q_push    (mid_push),
      .q_item    (mid_in_item),
      .q_full    (mid_full)
   );

   bpms_fifo #(
      .WIDTH ($bits(item_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data (mid_in_item),
      .full      (mid_full),
      .pop       (mid_pop),
      .pop_data  (mid_out_item),
      .empty     (mid_empty)
   );

   bpms_back u_back (
      .clock            (clock),
      .reset            (reset),
      .squelch_level    (squelch_ff),
      .level_correction (corr_ff),
      .q_empty          (mid_empty),
      .q_item           (mid_out_item),
      .q_pop            (mid_pop),
      .out_full         (res_full),
      .out_push         (res_push),
      .out_data         (res_in)
   );

   bpms_fifo #(
      .WIDTH ($bits(result_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_in),
      .full      (res_full),
      .pop       (pop),
      .pop_data  (res_out),
      .empty     (empty)
   );

   assign rsp_gated_re   = res_out.gated_re;
   assign rsp_gated_im   = res_out.gated_im;
   assign rsp_muted      = res_out.muted;
   assign rsp_block_done = res_out.block_done;
   assign rsp_inst_level = res_out.inst_level;
   assign rsp_avg_level  = res_out.avg_level;

endmodule

`default_nettype wire
